// ----- hw/rtl/lpr_pkg.sv -----
// Package for the line pixel rasterizer: widths, request codes and the
// request and response transaction structs. No dependencies.
`default_nettype none

package lpr_pkg;

   localparam int COORD_BITS = 12;
   localparam int WIDTH_BITS = 13;
   localparam int ADDR_BITS  = 24;
   localparam int COLOR_BITS = 24;
   // decision term spans -2*abs_dx .. 2*abs_dy (axes swapped when steep) plus one sign bit of margin
   localparam int DEC_BITS   = COORD_BITS + 3;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [COLOR_BITS-1:0] line_color;
   } lpr_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last_pixel;
   } lpr_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/line_pixel_rasterizer.sv -----
// An accepted transaction passes through the pixel stage and then the output register to rsp_valid.
// Throughput: one request per cycle while the output drains; the walker state updates at accept, and the
// pixel stage and the output register each hold one pixel under back-pressure.
// The address multiply (width times y) and the add of x sit between the pixel stage and the output register.
// Reset (synchronous, active high) clears the walker, empties both stages and
// sets image_width to 640.
`default_nettype none

module line_pixel_rasterizer (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  lpr_pkg::lpr_req_type        req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output lpr_pkg::lpr_rsp_type        rsp_data,
   input  wire                         csr_write_enable,
   input  wire [lpr_pkg::WIDTH_BITS-1:0] csr_write_data
);
   import lpr_pkg::*;

   localparam int CB = COORD_BITS;

   // walker state
   logic [CB-1:0]              cur_x_ff, cur_x_in;
   logic [CB-1:0]              cur_y_ff, cur_y_in;
   logic [CB-1:0]              stop_ff, stop_in;
   logic signed [DEC_BITS-1:0] dec_ff, dec_in;
   logic [CB-1:0]              adx_ff, adx_in;
   logic [CB-1:0]              ady_ff, ady_in;
   logic                       down_ff, down_in;
   logic                       steep_ff, steep_in;
   logic                       active_ff, active_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic [WIDTH_BITS-1:0]      width_ff;

   // pixel stage
   logic                       pix_valid_ff;
   logic [CB-1:0]              pix_x_ff, pix_y_ff;
   logic [COLOR_BITS-1:0]      pix_color_ff;
   logic                       pix_last_ff;

   // output register
   logic                       rsp_valid_ff;
   lpr_rsp_type                rsp_ff, rsp_in;

   logic                       req_accept;
   logic                       produce;
   logic                       last;
   logic                       out_free;
   logic                       pix_move;

   // start decode
   logic signed [CB:0]         dx, dy;
   logic [CB:0]                adx_full, ady_full;
   logic signed [DEC_BITS-1:0] two_adx, two_ady;
   logic signed [DEC_BITS-1:0] s_two_adx, s_two_ady;
   logic [CB+WIDTH_BITS-1:0]   product;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pix_move   = pix_valid_ff && out_free;
   assign req_ready  = !pix_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      dx       = $signed({1'b0, req_data.x_end}) - $signed({1'b0, req_data.x_start});
      dy       = $signed({1'b0, req_data.y_end}) - $signed({1'b0, req_data.y_start});
      adx_full = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
      ady_full = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
      two_adx  = $signed({2'b00, adx_full[CB-1:0], 1'b0});
      two_ady  = $signed({2'b00, ady_full[CB-1:0], 1'b0});
      s_two_adx = $signed({2'b00, adx_ff, 1'b0});
      s_two_ady = $signed({2'b00, ady_ff, 1'b0});

      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      stop_in   = stop_ff;
      dec_in    = dec_ff;
      adx_in    = adx_ff;
      ady_in    = ady_ff;
      down_in   = down_ff;
      steep_in  = steep_ff;
      active_in = active_ff;
      color_in  = color_ff;
      produce   = 1'b0;
      last      = 1'b0;

      if (req_data.req_type == REQ_START) begin
         adx_in   = adx_full[CB-1:0];
         ady_in   = ady_full[CB-1:0];
         down_in  = !((dx < 0 && dy < 0) || (dx > 0 && dy > 0));
         color_in = req_data.line_color;
         produce  = 1'b1;
         if (ady_full <= adx_full) begin
            steep_in = 1'b0;
            dec_in   = two_ady - $signed({3'b000, adx_full[CB-1:0]});
            if (!dx[CB]) begin
               cur_x_in = req_data.x_start;
               cur_y_in = req_data.y_start;
               stop_in  = req_data.x_end;
            end else begin
               cur_x_in = req_data.x_end;
               cur_y_in = req_data.y_end;
               stop_in  = req_data.x_start;
            end
            last = (cur_x_in == stop_in);
         end else begin
            steep_in = 1'b1;
            dec_in   = two_adx - $signed({3'b000, ady_full[CB-1:0]});
            if (!dy[CB]) begin
               cur_x_in = req_data.x_start;
               cur_y_in = req_data.y_start;
               stop_in  = req_data.y_end;
            end else begin
               cur_x_in = req_data.x_end;
               cur_y_in = req_data.y_end;
               stop_in  = req_data.y_start;
            end
            last = (cur_y_in == stop_in);
         end
         active_in = !last;
      end else if (active_ff) begin
         produce = 1'b1;
         if (!steep_ff) begin
            cur_x_in = cur_x_ff + 1'b1;
            if (dec_ff < 0) begin
               dec_in = dec_ff + s_two_ady;
            end else begin
               cur_y_in = down_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
               dec_in   = dec_ff + s_two_ady - s_two_adx;
            end
            last = (cur_x_in == stop_ff);
         end else begin
            cur_y_in = cur_y_ff + 1'b1;
            if (dec_ff <= 0) begin
               dec_in = dec_ff + s_two_adx;
            end else begin
               cur_x_in = down_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
               dec_in   = dec_ff + s_two_adx - s_two_ady;
            end
            last = (cur_y_in == stop_ff);
         end
         active_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         stop_ff   <= '0;
         dec_ff    <= '0;
         adx_ff    <= '0;
         ady_ff    <= '0;
         down_ff   <= 1'b0;
         steep_ff  <= 1'b0;
         active_ff <= 1'b0;
         color_ff  <= '0;
      end else if (req_accept) begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         stop_ff   <= stop_in;
         dec_ff    <= dec_in;
         adx_ff    <= adx_in;
         ady_ff    <= ady_in;
         down_ff   <= down_in;
         steep_ff  <= steep_in;
         active_ff <= active_in;
         color_ff  <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   // pixel stage: load on accept, otherwise drain into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (req_accept) begin
         pix_valid_ff <= produce;
      end else if (pix_move) begin
         pix_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_x_ff     <= cur_x_in;
         pix_y_ff     <= cur_y_in;
         pix_color_ff <= color_in;
         pix_last_ff  <= last;
      end
   end

   always_comb begin
      product              = (CB+WIDTH_BITS)'(width_ff) * (CB+WIDTH_BITS)'(pix_y_ff);
      rsp_in.pixel_x       = pix_x_ff;
      rsp_in.pixel_y       = pix_y_ff;
      rsp_in.pixel_address = ADDR_BITS'(product) + ADDR_BITS'(pix_x_ff);
      rsp_in.pixel_color   = pix_color_ff;
      rsp_in.last_pixel    = pix_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a step transaction with no line in progress leaves the pixel stage empty
   a_idle_step_drops: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.req_type == REQ_STEP && !active_ff |=> !pix_valid_ff)
      else $error("step without active line produced a pixel");

   // a start always yields a pixel carrying the new color
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.req_type == REQ_START |=>
         pix_valid_ff && pix_color_ff == $past(req_data.line_color))
      else $error("start transaction did not load its pixel");

   // the line ends with its last pixel
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      req_accept && produce && last |=> !active_ff && pix_last_ff)
      else $error("line still active after its last pixel");

   // a stalled pixel stage holds its pixel
   a_pix_hold: assert property (@(posedge clock) disable iff (reset)
      pix_valid_ff && !out_free |=> pix_valid_ff && $stable(pix_x_ff) && $stable(pix_y_ff))
      else $error("pixel stage lost data under back-pressure");

endmodule

`default_nettype wire

// ----- tb/line_pixel_rasterizer_test.sv -----
// Testbench for line_pixel_rasterizer: directed and random line walks checked against
// a Bresenham pixel predictor held in a scoreboard class. Depends on lpr_pkg and the
// line_pixel_rasterizer RTL only.
`default_nettype none

module line_pixel_rasterizer_test;
   import lpr_pkg::*;

   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;

   class pixel_scoreboard;
      logic [WIDTH_BITS-1:0] image_width;
      logic [COORD_BITS-1:0] cur_x, cur_y, stop_coord, abs_dx, abs_dy;
      logic [COLOR_BITS-1:0] held_color;
      int                    decision_term;
      bit                    minor_down, steep_mode, active;
      lpr_rsp_type           expected_pixels[$];
      int                    error_count;

      function new();
         image_width   = WIDTH_RESET;
         cur_x         = '0;
         cur_y         = '0;
         stop_coord    = '0;
         abs_dx        = '0;
         abs_dy        = '0;
         held_color    = '0;
         decision_term = 0;
         minor_down    = 1'b0;
         steep_mode    = 1'b0;
         active        = 1'b0;
         error_count   = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Walk the line for one accepted transaction and queue the pixel it produces.
      function void note_request(lpr_req_type req);
         int          x1, y1, x2, y2, dx, dy, adx, ady;
         bit          last;
         lpr_rsp_type px;
         if (req.req_type == REQ_START) begin
            x1 = int'(req.x_start);
            y1 = int'(req.y_start);
            x2 = int'(req.x_end);
            y2 = int'(req.y_end);
            dx = x2 - x1;
            dy = y2 - y1;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            abs_dx = COORD_BITS'(adx);
            abs_dy = COORD_BITS'(ady);
            minor_down = !((dx < 0 && dy < 0) || (dx > 0 && dy > 0));
            held_color = req.line_color;
            if (ady <= adx) begin
               steep_mode = 1'b0;
               decision_term = 2 * ady - adx;
               if (dx >= 0) begin
                  cur_x = req.x_start;
                  cur_y = req.y_start;
                  stop_coord = req.x_end;
               end else begin
                  cur_x = req.x_end;
                  cur_y = req.y_end;
                  stop_coord = req.x_start;
               end
               last = (cur_x == stop_coord);
            end else begin
               steep_mode = 1'b1;
               decision_term = 2 * adx - ady;
               if (dy >= 0) begin
                  cur_x = req.x_start;
                  cur_y = req.y_start;
                  stop_coord = req.y_end;
               end else begin
                  cur_x = req.x_end;
                  cur_y = req.y_end;
                  stop_coord = req.y_start;
               end
               last = (cur_y == stop_coord);
            end
            active = !last;
         end else begin
            // drop steps that arrive with no line in progress
            if (!active)
               return;
            adx = int'(abs_dx);
            ady = int'(abs_dy);
            if (!steep_mode) begin
               cur_x = cur_x + 1'b1;
               if (decision_term < 0) begin
                  decision_term += 2 * ady;
               end else begin
                  cur_y = minor_down ? cur_y - 1'b1 : cur_y + 1'b1;
                  decision_term += 2 * (ady - adx);
               end
               last = (cur_x == stop_coord);
            end else begin
               cur_y = cur_y + 1'b1;
               if (decision_term <= 0) begin
                  decision_term += 2 * adx;
               end else begin
                  cur_x = minor_down ? cur_x - 1'b1 : cur_x + 1'b1;
                  decision_term += 2 * (adx - ady);
               end
               last = (cur_y == stop_coord);
            end
            if (last)
               active = 1'b0;
         end
         px.pixel_x       = cur_x;
         px.pixel_y       = cur_y;
         px.pixel_address = ADDR_BITS'(int'(cur_x) + int'(image_width) * int'(cur_y));
         px.pixel_color   = held_color;
         px.last_pixel    = last;
         expected_pixels.insert(expected_pixels.size(), px);
      endfunction

      function void compare_field(string field_name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field_name, want, got);
            error_count++;
         end
      endfunction

      function void check_pixel(lpr_rsp_type got);
         lpr_rsp_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel expected none, got x=%0d y=%0d addr=0x%0h", $time,
                     got.pixel_x, got.pixel_y, got.pixel_address);
            error_count++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("pixel_x", want.pixel_x, got.pixel_x);
         compare_field("pixel_y", want.pixel_y, got.pixel_y);
         compare_field("pixel_address", want.pixel_address, got.pixel_address);
         compare_field("pixel_color", want.pixel_color, got.pixel_color);
         compare_field("last_pixel", want.last_pixel, got.last_pixel);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   lpr_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   lpr_rsp_type           rsp_data;
   logic                  csr_write_enable;
   logic [WIDTH_BITS-1:0] csr_write_data;

   pixel_scoreboard sb = new();
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_request      = 0;
   int idle_cycles       = 0;

   line_pixel_rasterizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Track every transaction on both channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_request(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_pixel(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("** line_pixel_rasterizer: FAILED **");
      $finish;
   end

   // Receiver: hold off when asked, otherwise stall at random.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_request--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   function automatic lpr_req_type random_step();
      lpr_req_type req;
      req.req_type   = REQ_STEP;
      req.x_start    = COORD_BITS'($urandom);
      req.y_start    = COORD_BITS'($urandom);
      req.x_end      = COORD_BITS'($urandom);
      req.y_end      = COORD_BITS'($urandom);
      req.line_color = COLOR_BITS'($urandom);
      return req;
   endfunction

   function automatic int random_coord();
      if ($urandom_range(99) < 15)
         return $urandom_range(1) ? (1 << COORD_BITS) - 1 : 0;
      return $urandom_range((1 << COORD_BITS) - 1);
   endfunction

   function automatic int nudge(int coord);
      int v;
      v = coord + int'($urandom_range(24)) - 12;
      if (v < 0)
         v = 0;
      if (v > (1 << COORD_BITS) - 1)
         v = (1 << COORD_BITS) - 1;
      return v;
   endfunction

   // Offer one transaction and hold it until accepted; returns at a falling edge.
   task automatic send_request(input lpr_req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic start_line(input int x1, input int y1, input int x2, input int y2,
                             input logic [COLOR_BITS-1:0] color);
      lpr_req_type req;
      req            = random_step();
      req.req_type   = REQ_START;
      req.x_start    = COORD_BITS'(x1);
      req.y_start    = COORD_BITS'(y1);
      req.x_end      = COORD_BITS'(x2);
      req.y_end      = COORD_BITS'(y2);
      req.line_color = color;
      send_request(req);
   endtask

   task automatic step_line(input int count);
      repeat (count)
         send_request(random_step());
   endtask

   // Idle the input and let every queued pixel drain before touching the register.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES)
         @(negedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.image_width = value;
   endtask

   // Mostly complete lines with random content; the rest are cut short, join random
   // points anywhere in the frame, or are stray steps.
   task automatic run_random_lines(input int pixel_goal);
      int          pixels, remaining, roll, steps, x1, y1, x2, y2, dx, dy, span;
      lpr_req_type req;
      pixels    = 0;
      remaining = 0;
      while (pixels < pixel_goal) begin
         roll = $urandom_range(99);
         if (roll >= 93) begin
            send_request(random_step());
            if (remaining > 0) begin
               pixels++;
               remaining--;
            end
         end else begin
            req          = random_step();
            req.req_type = REQ_START;
            if (roll < 85) begin
               x1 = random_coord();
               y1 = random_coord();
               x2 = nudge(x1);
               y2 = nudge(y1);
               case ($urandom_range(9))
                  0: y2 = y1;
                  1: x2 = x1;
                  default: ;
               endcase
               req.x_start = COORD_BITS'(x1);
               req.y_start = COORD_BITS'(y1);
               req.x_end   = COORD_BITS'(x2);
               req.y_end   = COORD_BITS'(y2);
            end
            send_request(req);
            pixels++;
            dx = int'(req.x_end) - int'(req.x_start);
            dy = int'(req.y_end) - int'(req.y_start);
            if (dx < 0)
               dx = -dx;
            if (dy < 0)
               dy = -dy;
            span = (dx > dy) ? dx : dy;
            remaining = span;
            if (roll < 70)
               steps = span + (($urandom_range(3) == 0) ? int'($urandom_range(2, 1)) : 0);
            else if (roll < 85)
               steps = $urandom_range(span);
            else
               steps = $urandom_range(8);
            repeat (steps) begin
               send_request(random_step());
               if (remaining > 0) begin
                  pixels++;
                  remaining--;
               end
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (7)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct   = 30;
      receiver_idle_pct = 51;

      // Directed lines at the reset width.
      step_line(1);
      start_line(4095, 4095, 4095, 4095, 24'hFFFFFF);
      start_line(10, 0, 0, 3, 24'h000000);
      step_line(3);
      start_line(2, 9, 5, 0, 24'h123456);
      step_line(4);
      start_line(4090, 7, 4095, 7, 24'hA5A5A5);
      step_line(6);
      start_line(0, 4095, 0, 4093, 24'h5A5A5A);
      step_line(2);
      start_line(0, 0, 3, 3, 24'h00FF00);
      step_line(3);

      settle();
      write_width(WIDTH_BITS'(4096));
      run_random_lines(170);

      settle();
      sender_idle_pct   = 51;
      receiver_idle_pct = 30;
      write_width(WIDTH_BITS'(1));
      run_random_lines(170);

      settle();
      write_width('0);
      run_random_lines(40);

      // Widest stride: addresses wrap past the top of the frame index.
      settle();
      write_width('1);
      run_random_lines(40);

      settle();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_width(WIDTH_BITS'($urandom_range(4096, 1)));
      hold_request = HOLD_CYCLES;
      run_random_lines(230);

      settle();
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("** line_pixel_rasterizer: PASSED **");
      end else begin
         $display("** line_pixel_rasterizer: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- line_pixel_rasterizer.f -----
hw/rtl/lpr_pkg.sv
hw/rtl/line_pixel_rasterizer.sv
tb/line_pixel_rasterizer_test.sv
